// ----- rtl/packet_slot_queue_framer_top_macros.svh -----
// Assertion helpers, clocked on clk_i and quiet while rst_ni is low.
`ifndef PACKET_SLOT_QUEUE_FRAMER_TOP_MACROS_SVH
`define PACKET_SLOT_QUEUE_FRAMER_TOP_MACROS_SVH

// same-cycle implication
`define PSQF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PSQF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/psqf_pkg.sv -----
`default_nettype none

package psqf_pkg;

  localparam int unsigned SLOT_MAX_W = 8;  // pointer width for the largest ring
  localparam int unsigned POS_MAX_W  = 6;  // byte position within the largest frame
  localparam int unsigned Q_DEPTH    = 4;

  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_DATA  = 2'd1;
  localparam logic [1:0] CMD_SEND  = 2'd2;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_LONG = 2'd1;
  localparam logic [1:0] STAT_FULL = 2'd2;

  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_FRAME  = 1'b1;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] channel_id;
    logic [7:0] payload_length;
    logic [7:0] data_byte;
  } psqf_in_t;

  typedef struct packed {
    logic       kind;
    logic [1:0] status;
    logic [7:0] frame_byte;
    logic       last_of_frame;
  } psqf_out_t;

  typedef enum logic [1:0] {
    OP_WRITE,
    OP_STATUS,
    OP_FRAME
  } op_e;

  // one entry of the front-to-back queue
  typedef struct packed {
    op_e                   op;
    logic [1:0]            status;
    logic [SLOT_MAX_W-1:0] slot;
    logic [POS_MAX_W-1:0]  pos;
    logic [7:0]            data;    // channel id for a start, payload byte for a write
    logic [7:0]            length;
    logic                  have;    // frame has a committed slot behind it
  } psqf_op_t;

  typedef enum logic [1:0] {
    BK_HEAD,
    BK_LEN,
    BK_FRAME
  } bk_state_e;

endpackage

`default_nettype wire

// ----- rtl/psqf_fifo.sv -----
`default_nettype none

module psqf_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  input  wire psqf_pkg::psqf_op_t  din_i,
  output      logic                full_o,
  input  wire logic                pop_i,
  output      psqf_pkg::psqf_op_t  dout_o,
  output      logic                empty_o
);
  import psqf_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  psqf_op_t            mem_q [DEPTH];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign dout_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= din_i;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/psqf_front.sv -----
`default_nettype none

module psqf_front #(
  parameter int unsigned SLOTS       = 16,
  parameter int unsigned FRAME_BYTES = 22,
  parameter int unsigned MAX_PAYLOAD = 20
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output      logic                in_ready_o,
  input  wire psqf_pkg::psqf_in_t  in_data_i,
  output      logic                push_o,
  output      psqf_pkg::psqf_op_t  op_o,
  input  wire logic                full_i
);
  import psqf_pkg::*;

  localparam int unsigned SlotW = $clog2(SLOTS);

  logic [SlotW-1:0] wr_slot_q, wr_slot_d, rd_slot_q, rd_slot_d;
  logic [SlotW-1:0] wr_next, rd_next;
  logic [7:0]       fill_q, fill_d, pend_q, pend_d, fill_inc;
  logic             filling_q, filling_d;
  logic             accept;
  logic [8:0]       data_pos;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign wr_next    = (wr_slot_q == SlotW'(SLOTS - 1)) ? '0 : wr_slot_q + 1'b1;
  assign rd_next    = (rd_slot_q == SlotW'(SLOTS - 1)) ? '0 : rd_slot_q + 1'b1;
  assign fill_inc   = fill_q + 8'd1;
  assign data_pos   = {1'b0, fill_q} + 9'd2;

  always_comb begin
    wr_slot_d = wr_slot_q;
    rd_slot_d = rd_slot_q;
    fill_d    = fill_q;
    pend_d    = pend_q;
    filling_d = filling_q;
    push_o    = 1'b0;
    op_o      = '{op: OP_WRITE, status: STAT_OK, slot: SLOT_MAX_W'(wr_slot_q),
                  pos: POS_MAX_W'(data_pos), data: in_data_i.data_byte,
                  length: in_data_i.payload_length, have: 1'b0};
    if (accept) begin
      case (in_data_i.command)
        CMD_START: begin
          push_o    = 1'b1;
          op_o.op   = OP_STATUS;
          op_o.data = in_data_i.channel_id;
          filling_d = 1'b0;  // an open message is dropped either way
          if (in_data_i.payload_length > 8'(MAX_PAYLOAD)) begin
            op_o.status = STAT_LONG;
          end else if (wr_next == rd_slot_q) begin
            op_o.status = STAT_FULL;
          end else if (in_data_i.payload_length == 8'd0) begin
            wr_slot_d = wr_next;
          end else begin
            filling_d = 1'b1;
            pend_d    = in_data_i.payload_length;
            fill_d    = 8'd0;
          end
        end
        CMD_DATA: begin
          if (filling_q) begin
            // bytes past the end of the slot are counted, not stored
            push_o = (data_pos < 9'(FRAME_BYTES));
            fill_d = fill_inc;
            if (fill_inc >= pend_q) begin
              filling_d = 1'b0;
              wr_slot_d = wr_next;
            end
          end
        end
        CMD_SEND: begin
          push_o    = 1'b1;
          op_o.op   = OP_FRAME;
          op_o.slot = SLOT_MAX_W'(rd_slot_q);
          op_o.have = (rd_slot_q != wr_slot_q);
          if (rd_slot_q != wr_slot_q) begin
            rd_slot_d = rd_next;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_slot_q <= '0;
      rd_slot_q <= '0;
      fill_q    <= '0;
      pend_q    <= '0;
      filling_q <= 1'b0;
    end else begin
      wr_slot_q <= wr_slot_d;
      rd_slot_q <= rd_slot_d;
      fill_q    <= fill_d;
      pend_q    <= pend_d;
      filling_q <= filling_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/psqf_back.sv -----
`default_nettype none

module psqf_back #(
  parameter int unsigned SLOTS       = 16,
  parameter int unsigned FRAME_BYTES = 22
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire psqf_pkg::psqf_op_t  op_i,
  input  wire logic                empty_i,
  output      logic                pop_o,
  output      logic                out_valid_o,
  input  wire logic                out_ready_i,
  output      psqf_pkg::psqf_out_t out_data_o
);
  import psqf_pkg::*;

  localparam int unsigned SlotW = $clog2(SLOTS);
  localparam int unsigned Depth = SLOTS * FRAME_BYTES;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned PosW  = $clog2(FRAME_BYTES);

  typedef struct packed {
    logic            kind;
    logic [1:0]      status;
    logic            have;
    logic [PosW-1:0] pos;
    logic            last;
  } stage_t;

  logic [7:0]       mem_q [Depth];
  logic [7:0]       rdata_q;
  logic [7:0]       len_q;

  bk_state_e        state_q, state_d;
  logic [PosW-1:0]  k_q, k_d;
  stage_t           s1_q, s1_d;
  logic             s1_valid_q;
  psqf_out_t        out_q;
  logic             out_valid_q;

  logic             s1_move, can_issue, issue;
  logic             wr_en, rd_en;
  logic [PosW-1:0]  wr_pos, rd_pos;
  logic [7:0]       wr_data;
  logic [AddrW-1:0] base, wr_addr, rd_addr;
  logic             keep;

  // one byte read a cycle while s1 can take it; the read result sits in rdata_q while s1 waits
  assign s1_move   = s1_valid_q && (!out_valid_q || out_ready_i);
  assign can_issue = !s1_valid_q || s1_move;
  assign base      = AddrW'(op_i.slot[SlotW-1:0]) * AddrW'(FRAME_BYTES);
  assign wr_addr   = base + AddrW'(wr_pos);
  assign rd_addr   = base + AddrW'(rd_pos);

  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    pop_o   = 1'b0;
    wr_en   = 1'b0;
    wr_pos  = PosW'(op_i.pos);
    wr_data = op_i.data;
    rd_en   = 1'b0;
    rd_pos  = k_q;
    issue   = 1'b0;
    s1_d    = '{kind: KIND_STATUS, status: op_i.status, have: op_i.have,
                pos: k_q, last: 1'b0};
    case (state_q)
      BK_HEAD: begin
        if (!empty_i) begin
          case (op_i.op)
            OP_WRITE: begin
              wr_en = 1'b1;
              pop_o = 1'b1;
            end
            OP_STATUS: begin
              if (op_i.status == STAT_OK) begin
                wr_en   = 1'b1;
                wr_pos  = '0;
                state_d = BK_LEN;
              end else if (can_issue) begin
                issue = 1'b1;
                pop_o = 1'b1;
              end
            end
            OP_FRAME: begin
              if (can_issue) begin
                rd_en     = 1'b1;
                rd_pos    = '0;
                issue     = 1'b1;
                s1_d.kind = KIND_FRAME;
                s1_d.pos  = '0;
                k_d       = PosW'(1);
                state_d   = BK_FRAME;
              end
            end
            default: begin
              pop_o = 1'b1;
            end
          endcase
        end
      end
      BK_LEN: begin
        // length byte; rewriting it while the status waits is harmless
        wr_en   = 1'b1;
        wr_pos  = PosW'(1);
        wr_data = op_i.length;
        if (can_issue) begin
          issue   = 1'b1;
          pop_o   = 1'b1;
          state_d = BK_HEAD;
        end
      end
      BK_FRAME: begin
        if (can_issue) begin
          rd_en     = 1'b1;
          issue     = 1'b1;
          s1_d.kind = KIND_FRAME;
          if (k_q == PosW'(FRAME_BYTES - 1)) begin
            s1_d.last = 1'b1;
            pop_o     = 1'b1;
            k_d       = '0;
            state_d   = BK_HEAD;
          end else begin
            k_d = k_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = BK_HEAD;
      end
    endcase
  end

  // with a slot behind the frame, header bytes always pass; payload bytes only below the declared length
  assign keep = s1_q.have && ((s1_q.pos < PosW'(2)) ||
                ({1'b0, 8'(s1_q.pos)} < ({1'b0, len_q} + 9'd2)));

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
    if (s1_move && s1_q.kind && (s1_q.pos == PosW'(1))) begin
      len_q <= rdata_q;
    end
    if (issue) begin
      s1_q <= s1_d;
    end
    if (s1_move) begin
      out_q.kind          <= s1_q.kind;
      out_q.status        <= s1_q.kind ? STAT_OK : s1_q.status;
      out_q.frame_byte    <= (s1_q.kind && keep) ? rdata_q : 8'd0;
      out_q.last_of_frame <= s1_q.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_HEAD;
      k_q         <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      if (issue) begin
        s1_valid_q <= 1'b1;
      end else if (s1_move) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_move) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ----- rtl/packet_slot_queue_framer_top.sv -----
`default_nettype none

// Packet slot ring feeding a fixed-length transmit frame. The front end takes
// one word per cycle while the queue is not full, and the front keeps the
// ring pointers, so status codes follow the item order exactly. Work then
// passes through a 4-entry queue to the back end, which owns the slot memory
// (one write and one registered read port): a payload byte is one write
// there, an accepted start writes the channel id and then the length byte
// (both share the write port), and a send reads FRAME_BYTES frame bytes, one
// per cycle from the read port while the output pipeline is not stalled.
// Results leave through a two-stage output pipeline (s1 with rdata_q, then
// out_q). The slot memory needs no clearing after reset; a send from an
// empty ring returns FRAME_BYTES zero bytes.
module packet_slot_queue_framer_top #(
  parameter int unsigned SLOTS       = 16,
  parameter int unsigned FRAME_BYTES = 22,
  parameter int unsigned MAX_PAYLOAD = 20
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output      logic                in_ready_o,
  input  wire psqf_pkg::psqf_in_t  in_data_i,
  output      logic                out_valid_o,
  input  wire logic                out_ready_i,
  output      psqf_pkg::psqf_out_t out_data_o
);
  import psqf_pkg::*;

  `include "packet_slot_queue_framer_top_macros.svh"

  psqf_op_t q_din, q_dout;
  logic     q_push, q_full, q_pop, q_empty;

  psqf_front #(
    .SLOTS       (SLOTS),
    .FRAME_BYTES (FRAME_BYTES),
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .push_o     (q_push),
    .op_o       (q_din),
    .full_i     (q_full)
  );

  psqf_fifo #(
    .DEPTH (Q_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .din_i   (q_din),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .dout_o  (q_dout),
    .empty_o (q_empty)
  );

  psqf_back #(
    .SLOTS       (SLOTS),
    .FRAME_BYTES (FRAME_BYTES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_i        (q_dout),
    .empty_i     (q_empty),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  `PSQF_ASSERT_IMP(a_no_push_full, q_push, !q_full, "queue pushed while full")
  `PSQF_ASSERT_IMP(a_last_is_frame, out_valid_o && out_data_o.last_of_frame,
                   out_data_o.kind == KIND_FRAME, "frame end on a status word")
  `PSQF_ASSERT_IMP(a_status_clean, out_valid_o && (out_data_o.kind == KIND_STATUS),
                   out_data_o.frame_byte == 8'd0, "status word carries a byte")
  `PSQF_ASSERT_NXT(a_no_pop_empty, q_empty && !q_push, !q_pop || q_empty,
                   "queue popped while empty")

endmodule

`default_nettype wire

// ----- test/packet_slot_queue_framer_checker.sv -----
`timescale 1ns / 100ps

module packet_slot_queue_framer_checker #(
  parameter int unsigned SLOTS       = 16,
  parameter int unsigned FRAME_BYTES = 22,
  parameter int unsigned MAX_PAYLOAD = 20
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  input  wire logic                in_ready_i,
  input  wire psqf_pkg::psqf_in_t  in_data_i,
  input  wire logic                out_valid_i,
  input  wire logic                out_ready_i,
  input  wire psqf_pkg::psqf_out_t out_data_i,
  output int                       err_count_o,
  output int                       pend_count_o,
  output int                       frame_count_o,
  output int                       long_count_o,
  output int                       full_count_o
);

  import psqf_pkg::*;

  localparam int unsigned HEADER_BYTES = 2;

  logic [7:0]  slot_mem [SLOTS*FRAME_BYTES];
  int unsigned wr_slot    = 0;
  int unsigned rd_slot    = 0;
  int unsigned got_bytes  = 0;
  int unsigned want_bytes = 0;
  bit          open_msg   = 1'b0;

  psqf_out_t   due_results [$];
  int          errs   = 0;
  int          frames = 0;
  int          longs  = 0;
  int          fulls  = 0;

  initial begin
    for (int i = 0; i < SLOTS*FRAME_BYTES; i++) slot_mem[i] = 8'h00;
  end

  function automatic int unsigned next_slot(input int unsigned s);
    return (s + 1 >= SLOTS) ? 0 : s + 1;
  endfunction

  // bytes past the end of a slot are dropped
  function automatic void put_byte(input int unsigned slot, input int unsigned pos,
                                   input logic [7:0] v);
    if (pos < FRAME_BYTES) slot_mem[slot*FRAME_BYTES + pos] = v;
  endfunction

  function automatic logic [7:0] get_byte(input int unsigned slot, input int unsigned pos);
    if (pos < FRAME_BYTES) return slot_mem[slot*FRAME_BYTES + pos];
    return 8'h00;
  endfunction

  task automatic step_ring(input psqf_in_t w);
    psqf_out_t   r;
    bit          have;
    int unsigned used;
    r = '0;
    case (w.command)
      CMD_START: begin
        r.kind = KIND_STATUS;
        open_msg = 1'b0;  // any start drops an unfinished message
        if (w.payload_length > MAX_PAYLOAD) begin
          r.status = STAT_LONG;
          longs++;
        end else if (next_slot(wr_slot) == rd_slot) begin
          r.status = STAT_FULL;
          fulls++;
        end else begin
          put_byte(wr_slot, 0, w.channel_id);
          put_byte(wr_slot, 1, w.payload_length);
          if (w.payload_length == 8'd0) begin
            wr_slot = next_slot(wr_slot);
          end else begin
            open_msg   = 1'b1;
            want_bytes = w.payload_length;
            got_bytes  = 0;
          end
          r.status = STAT_OK;
        end
        due_results.push_back(r);
      end
      CMD_DATA: begin
        if (open_msg) begin
          put_byte(wr_slot, HEADER_BYTES + got_bytes, w.data_byte);
          got_bytes = (got_bytes + 1) & 8'hFF;
          if (got_bytes >= want_bytes) begin
            open_msg = 1'b0;
            wr_slot  = next_slot(wr_slot);
          end
        end
      end
      CMD_SEND: begin
        have = (rd_slot != wr_slot);
        used = have ? HEADER_BYTES + get_byte(rd_slot, 1) : 0;
        for (int k = 0; k < FRAME_BYTES; k++) begin
          r.kind          = KIND_FRAME;
          r.status        = STAT_OK;
          r.frame_byte    = (have && k < used) ? get_byte(rd_slot, k) : 8'h00;
          r.last_of_frame = (k == FRAME_BYTES - 1);
          due_results.push_back(r);
        end
        if (have) rd_slot = next_slot(rd_slot);
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i) begin
    psqf_out_t got;
    psqf_out_t want;
    if (rst_ni) begin
      // results first: a word taken at this edge cannot already have an answer out
      if (out_valid_i && out_ready_i) begin
        got = out_data_i;
        if (due_results.size() == 0) begin
          errs++;
          if (errs <= 10)
            $display("%0t: unexpected word kind %0d status %0d byte %02h last %0d",
                     $realtime, got.kind, got.status, got.frame_byte, got.last_of_frame);
        end else begin
          want = due_results.pop_front();
          if (want.kind == KIND_FRAME && want.last_of_frame) frames++;
          if (got.kind !== want.kind || got.status !== want.status ||
              got.frame_byte !== want.frame_byte ||
              got.last_of_frame !== want.last_of_frame) begin
            errs++;
            if (errs <= 10)
              $display("%0t: mismatch: expected kind %0d status %0d byte %02h last %0d, got kind %0d status %0d byte %02h last %0d",
                       $realtime, want.kind, want.status, want.frame_byte,
                       want.last_of_frame, got.kind, got.status, got.frame_byte,
                       got.last_of_frame);
          end
        end
      end
      if (in_valid_i && in_ready_i) step_ring(in_data_i);
    end
    err_count_o   <= errs;
    pend_count_o  <= due_results.size();
    frame_count_o <= frames;
    long_count_o  <= longs;
    full_count_o  <= fulls;
  end

endmodule

// ----- test/tb_packet_slot_queue_framer_top.sv -----
`timescale 1ns / 100ps

module tb_packet_slot_queue_framer_top;

  import psqf_pkg::*;

  localparam int unsigned SLOTS        = 16;
  localparam int unsigned FRAME_BYTES  = 22;
  localparam int unsigned MAX_PAYLOAD  = 20;
  localparam int unsigned ITEM_TARGET  = 150;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned DRAIN_CYCLES = 64;
  localparam int unsigned CYCLE_LIMIT  = 300000;
  localparam logic [1:0]  CMD_UNUSED   = 2'd3;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  psqf_in_t  in_data_i;
  logic      out_valid_o;
  logic      out_ready_i;
  psqf_out_t out_data_o;

  int          mismatches;
  int          pending;
  int          frames;
  int          long_refusals;
  int          full_refusals;
  int unsigned words_sent = 0;
  int unsigned cycles     = 0;
  bit          idle_en    = 1'b1;
  bit          hold_req   = 1'b0;

  packet_slot_queue_framer_top #(
    .SLOTS       (SLOTS),
    .FRAME_BYTES (FRAME_BYTES),
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  packet_slot_queue_framer_checker #(
    .SLOTS       (SLOTS),
    .FRAME_BYTES (FRAME_BYTES),
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .in_data_i     (in_data_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_data_i    (out_data_o),
    .err_count_o   (mismatches),
    .pend_count_o  (pending),
    .frame_count_o (frames),
    .long_count_o  (long_refusals),
    .full_count_o  (full_refusals)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still due", cycles, pending);
      $display("packet_slot_queue_framer_top test failed");
      $finish;
    end
  end

  // receiver: random back-pressure, or one long hold-off on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (idle_en) begin
        out_ready_i <= ($urandom_range(99) >= 21);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  function automatic psqf_in_t make_word(input logic [1:0] cmd, input logic [7:0] ch,
                                         input logic [7:0] len, input logic [7:0] dat);
    psqf_in_t w;
    w.command        = cmd;
    w.channel_id     = ch;
    w.payload_length = len;
    w.data_byte      = dat;
    return w;
  endfunction

  // valid stays up between back-to-back words; it only drops on an idle cycle
  task automatic push_word(input psqf_in_t w);
    while (idle_en && $urandom_range(99) < 21) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic offer_send();
    push_word(make_word(CMD_SEND, 8'($urandom_range(255)), 8'($urandom_range(255)),
                        8'($urandom_range(255))));
    words_sent++;
  endtask

  // start plus payload; mostly short, a few at the limit or over it
  task automatic offer_message(input bit short_only, input bit may_cut);
    int unsigned len;
    int unsigned keep;
    int          pick;
    pick = $urandom_range(99);
    if (short_only)     len = $urandom_range(0, 1);
    else if (pick < 50) len = $urandom_range(0, 3);
    else if (pick < 80) len = $urandom_range(4, MAX_PAYLOAD - 1);
    else if (pick < 90) len = MAX_PAYLOAD;
    else                len = $urandom_range(MAX_PAYLOAD + 1, 255);
    push_word(make_word(CMD_START, 8'($urandom_range(255)), 8'(len),
                        8'($urandom_range(255))));
    words_sent++;
    keep = (len > MAX_PAYLOAD) ? 0 : len;
    // a cut message is left open for the next start to abandon
    if (may_cut && keep > 1 && $urandom_range(99) < 10) keep = $urandom_range(1, keep - 1);
    for (int i = 0; i < keep; i++) begin
      push_word(make_word(CMD_DATA, 8'($urandom_range(255)), 8'($urandom_range(255)),
                          8'($urandom_range(255))));
      words_sent++;
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin
    int r;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_ready_i = 1'b0;
    rst_ni      = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty ring, zero length, refusals, stray words, abandon
    push_word(make_word(CMD_SEND,   8'h00, 8'h00, 8'h00));
    push_word(make_word(CMD_START,  8'hFF, 8'h00, 8'hFF));
    push_word(make_word(CMD_SEND,   8'hFF, 8'hFF, 8'hFF));
    push_word(make_word(CMD_START,  8'h00, 8'(MAX_PAYLOAD + 1), 8'h00));
    push_word(make_word(CMD_START,  8'hAA, 8'hFF, 8'h55));
    push_word(make_word(CMD_DATA,   8'h00, 8'h00, 8'h5A));
    push_word(make_word(CMD_UNUSED, 8'hFF, 8'hFF, 8'hFF));
    push_word(make_word(CMD_START,  8'h55, 8'h03, 8'h00));
    push_word(make_word(CMD_DATA,   8'h00, 8'h00, 8'h11));
    push_word(make_word(CMD_START,  8'h81, 8'h02, 8'h00));
    push_word(make_word(CMD_DATA,   8'h00, 8'h00, 8'hFF));
    push_word(make_word(CMD_DATA,   8'hFF, 8'hFF, 8'h00));
    push_word(make_word(CMD_DATA,   8'h00, 8'h00, 8'h77));
    push_word(make_word(CMD_SEND,   8'h00, 8'h00, 8'h00));
    push_word(make_word(CMD_SEND,   8'h00, 8'h00, 8'h00));
    push_word(make_word(CMD_START,  8'h00, 8'(MAX_PAYLOAD), 8'h00));
    words_sent = 16;

    for (int i = 0; i < 6; i++) begin
      offer_message(1'b0, 1'b1);
      if ($urandom_range(1)) offer_send();
    end

    // no sends: the ring must fill, then a too-long start on a full ring
    for (int i = 0; i < 18; i++) offer_message(1'b1, 1'b0);
    push_word(make_word(CMD_START, 8'hC3, 8'hFF, 8'h3C));
    words_sent++;

    // receiver holds off while sends keep coming
    hold_req = 1'b1;
    for (int i = 0; i < 12; i++) offer_send();
    wait_drained();

    idle_en = 1'b0;
    for (int i = 0; i < 6; i++) begin
      offer_message(1'b0, 1'b1);
      offer_send();
    end
    idle_en = 1'b1;

    while (words_sent < ITEM_TARGET) begin
      r = $urandom_range(99);
      if (r < 65) begin
        offer_message(1'b0, 1'b1);
      end else if (r < 90) begin
        offer_send();
      end else if (r < 95) begin
        push_word(make_word(CMD_UNUSED, 8'($urandom_range(255)), 8'($urandom_range(255)),
                            8'($urandom_range(255))));
        words_sent++;
      end else begin
        push_word(make_word(CMD_DATA, 8'($urandom_range(255)), 8'($urandom_range(255)),
                            8'($urandom_range(255))));
        words_sent++;
      end
    end
    repeat (3) offer_send();

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d words over %0d cycles; checked %0d frames and", words_sent, cycles,
             frames);
    $display("  %0d too-long and %0d ring-full refusals, with one long output hold-off",
             long_refusals, full_refusals);
    if (mismatches == 0 && pending == 0) begin
      $display("packet_slot_queue_framer_top test passed");
    end else begin
      $display("%0d mismatches, %0d words still due", mismatches, pending);
      $display("packet_slot_queue_framer_top test failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/psqf_pkg.sv
rtl/psqf_fifo.sv
rtl/psqf_front.sv
rtl/psqf_back.sv
rtl/packet_slot_queue_framer_top.sv
test/packet_slot_queue_framer_checker.sv
test/tb_packet_slot_queue_framer_top.sv
